### design/ikdth_pkg.sv
// Package for the integer key decimal text hash block.
// Holds the shared constants, the controller state type and the command and
// status structs that pass between the controller and the datapath.
package ikdth_pkg;

    localparam int KEY_W  = 64;   // width of the key field on the input stream
    localparam int HASH_W = 32;   // width of the hash result

    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
    localparam logic [HASH_W-1:0] FMIX_MUL  = 32'h3243f6a9;
    localparam logic [5:0]        CHR_ZERO  = 6'd48;
    localparam logic [5:0]        CHR_MINUS = 6'd45;
    localparam logic [4:0]        DEC_BASE  = 5'd10;
    localparam int                FMIX_SHIFT = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_DIV_B,
        ST_MIX_LAST,
        ST_SIGN,
        ST_SEED,
        ST_FIN,
        ST_OUT
    } ikdth_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture key magnitude and sign, clear accumulators
        logic div_a;     // first half of divide by ten
        logic div_b;     // second half of divide by ten, emit one digit
        logic mix;       // fold the held digit into the hash
        logic mix_sign;  // fold a minus sign into the hash
        logic seed;      // apply the scaled start value
        logic fin;       // finalizer first xor-shift and multiply
        logic out_load;  // finalizer last xor-shift into the output register
    } ikdth_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic q_zero;    // the quotient just produced is zero
        logic neg;       // the key is negative
    } ikdth_stat_t;

endpackage

### design/integer_key_decimal_text_hash_top.sv
// Integer key decimal text hash, top level: controller plus datapath.
// Per key: the key is taken in idle, then each decimal digit passes through the
// divide states DIV_A and DIV_B, then MIX_LAST, SIGN for a negative key, SEED, FIN and
// OUT; n, the number of digits, is at most 19 at KEY_BITS = 64. One key at a time: no new
// key is taken until OUT loads the result, as all digits share the divide-by-ten unit.
// Reset (aresetn low, synchronous) returns the controller to idle and drops m_tvalid.
module integer_key_decimal_text_hash_top
    import ikdth_pkg::*;
#(
    parameter int KEY_BITS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [KEY_W-1:0]  s_tdata,   // [63:0] key
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [HASH_W-1:0] m_tdata    // [31:0] hash
);

    ikdth_cmd_t  cmd;
    ikdth_stat_t stat;

    ikdth_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ikdth_dp #(
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk (aclk),
        .key  (s_tdata),
        .cmd  (cmd),
        .stat (stat),
        .hash (m_tdata)
    );

endmodule

### design/ikdth_ctrl.sv
// Controller state machine for the integer key decimal text hash block.
// Depends on ikdth_pkg; drives commands to ikdth_dp and owns the stream handshakes.
module ikdth_ctrl
    import ikdth_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  ikdth_stat_t stat,
    output ikdth_cmd_t  cmd
);

    ikdth_state_t state_reg, state_next;
    logic         first_reg, first_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DIV_A;
                end
            end
            ST_DIV_A:    state_next = ST_DIV_B;
            ST_DIV_B:    state_next = stat.q_zero ? ST_MIX_LAST : ST_DIV_A;
            ST_MIX_LAST: state_next = stat.neg ? ST_SIGN : ST_SEED;
            ST_SIGN:     state_next = ST_SEED;
            ST_SEED:     state_next = ST_FIN;
            ST_FIN:      state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Commands and flags.
    always_comb begin
        cmd            = '0;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    first_next = 1'b1;
                end
            end
            ST_DIV_A: begin
                // The digit from the previous pass is mixed while the next divide starts.
                cmd.div_a  = 1'b1;
                cmd.mix    = !first_reg;
                first_next = 1'b0;
            end
            ST_DIV_B:    cmd.div_b    = 1'b1;
            ST_MIX_LAST: cmd.mix      = 1'b1;
            ST_SIGN:     cmd.mix_sign = 1'b1;
            ST_SEED:     cmd.seed     = 1'b1;
            ST_FIN:      cmd.fin      = 1'b1;
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### design/ikdth_dp.sv
// Datapath for the integer key decimal text hash block: divide-by-ten unit,
// digit mixer, seed scaling, finalizer and output register. Depends on ikdth_pkg.
module ikdth_dp
    import ikdth_pkg::*;
#(
    parameter int KEY_BITS = 64
) (
    input  logic              aclk,
    input  logic [KEY_W-1:0]  key,
    input  ikdth_cmd_t        cmd,
    output ikdth_stat_t       stat,
    output logic [HASH_W-1:0] hash
);

    logic [KEY_BITS-1:0] key_v;
    logic                key_neg;
    logic [KEY_BITS-1:0] mag_reg, qa_reg, qa;
    logic [KEY_BITS-1:0] qb1, qb2, qb3, q_est, q_fin;
    logic                neg_reg;
    logic [3:0]          digit_reg, digit;
    logic [4:0]          q10_lo, r5;
    logic                corr;
    logic [5:0]          chr;
    logic [HASH_W-1:0]   acc_reg, pw_reg, h_reg, prod_reg, hash_reg;
    logic [HASH_W-1:0]   chr_term, h_mix;

    assign key_v   = key[KEY_BITS-1:0];
    assign key_neg = key_v[KEY_BITS-1];

    // Divide by ten as a sum of shifted copies (about 0.8 * n), split over the div_a
    // and div_b steps, then a remainder check on the low bits corrects the quotient by one.
    assign qa    = (mag_reg >> 1) + (mag_reg >> 2) + (((mag_reg >> 1) + (mag_reg >> 2)) >> 4);
    assign qb1   = qa_reg + (qa_reg >> 8);
    assign qb2   = qb1 + (qb1 >> 16);
    assign qb3   = qb2 + (qb2 >> 32);
    assign q_est = qb3 >> 3;
    assign q10_lo = {q_est[1:0], 3'b000} + {q_est[3:0], 1'b0};
    assign r5     = mag_reg[4:0] - q10_lo;
    assign corr   = (r5 >= DEC_BASE);
    assign digit  = corr ? 4'(r5 - DEC_BASE) : r5[3:0];
    assign q_fin  = q_est + KEY_BITS'(corr);

    assign stat.q_zero = (q_fin == '0);
    assign stat.neg    = neg_reg;

    // Digits arrive least significant first, so each character is weighted by
    // the running power of 33 instead of multiplying the hash forward.
    assign chr      = cmd.mix_sign ? CHR_MINUS : (CHR_ZERO + 6'(digit_reg));
    assign chr_term = HASH_W'(chr) * pw_reg;
    assign h_mix    = h_reg ^ (h_reg >> FMIX_SHIFT);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg <= key_neg;
            mag_reg <= key_neg ? (~key_v + KEY_BITS'(1)) : key_v;
            acc_reg <= '0;
            pw_reg  <= HASH_W'(1);
        end else begin
            if (cmd.div_b) begin
                mag_reg   <= q_fin;
                digit_reg <= digit;
            end
            if (cmd.mix || cmd.mix_sign) begin
                acc_reg <= acc_reg + chr_term;
                pw_reg  <= (pw_reg << 5) + pw_reg;
            end
        end
        if (cmd.div_a) begin
            qa_reg <= qa;
        end
        if (cmd.seed) begin
            h_reg <= HASH_SEED * pw_reg + acc_reg;
        end
        if (cmd.fin) begin
            prod_reg <= h_mix * FMIX_MUL;
        end
        if (cmd.out_load) begin
            hash_reg <= prod_reg ^ (prod_reg >> FMIX_SHIFT);
        end
    end

    assign hash = hash_reg;

endmodule

### design/ikdth_checker.sv
// Port-level checker for the integer key decimal text hash block, bound to the
// top level. Depends on ikdth_pkg for the port widths.
module ikdth_checker
    import ikdth_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [HASH_W-1:0] m_tdata
);

    // A result that is offered stays offered until the transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped before transfer");

    // The offered hash does not change while it waits for the transfer.
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed before transfer");

    // Reset leaves no result on the output.
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // The block works on one key at a time once a key is taken.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a key is in progress");

    // A new result appears exactly when the block goes back to idle.
    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result appeared while the block was still busy");

endmodule

bind integer_key_decimal_text_hash_top ikdth_checker u_ikdth_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/tb.sv
// Self-checking testbench for integer_key_decimal_text_hash_top.
// It predicts the finalized hash of each key's decimal text in its own model and needs
// ikdth_pkg and the top level, with its controller and datapath, from the design folder.
module tb
    import ikdth_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_BITS      = 64;
    localparam int STALL_LIMIT   = 3000;  // cycles without any transfer before giving up
    localparam int LONG_HOLD     = 400;   // receiver hold-off for the backpressure check
    localparam int SETTLE_CYCLES = 60;    // a little more than the longest key latency
    localparam int RANDOM_KEYS   = 1000;

    localparam logic [31:0] TEXT_SEED  = 32'd5381;
    localparam logic [31:0] MIX_MULT   = 32'h3243f6a9;
    localparam logic [31:0] ASCII_ZERO = 32'd48;
    localparam logic [31:0] ASCII_DASH = 32'd45;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [KEY_W-1:0]  s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [HASH_W-1:0] m_tdata;

    logic [HASH_W-1:0] hash_q [$];
    logic              idle_on = 1'b1;
    logic              hold_req = 1'b0;
    int                err_count = 0;
    int                keys_sent = 0;
    int                neg_sent = 0;
    int                hashes_checked = 0;
    int                quiet_cycles = 0;

    logic [63:0] directed_keys [0:19] = '{
        64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99, 64'd100,
        64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
        64'd999999999999999999, 64'd1000000000000000000, -64'sd1000000000000000000,
        64'd12345, 64'h0000_0000_ffff_ffff, 64'h0000_0001_0000_0000,
        64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555
    };

    integer_key_decimal_text_hash_top #(
        .KEY_BITS(KEY_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Writes the key as signed decimal text and runs the djb2 hash and finalizer over it.
    function automatic logic [31:0] decimal_text_hash(input logic [63:0] raw);
        logic [63:0] keep_mask;
        logic [63:0] val;
        logic [63:0] mag;
        logic        is_neg;
        logic [3:0]  digit [0:19];
        int          n;
        logic [31:0] h;
        keep_mask = {64{1'b1}} >> (64 - KEY_BITS);
        val = raw & keep_mask;
        is_neg = val[KEY_BITS-1];
        mag = is_neg ? ((~val + 64'd1) & keep_mask) : val;
        n = 0;
        do begin
            digit[n] = 4'(mag % 64'd10);
            n++;
            mag = mag / 64'd10;
        end while (mag != 64'd0 && n < 20);
        h = TEXT_SEED;
        if (is_neg)
            h = h * 32'd33 + ASCII_DASH;
        for (int i = n - 1; i >= 0; i--)
            h = h * 32'd33 + ASCII_ZERO + 32'(digit[i]);
        h = h ^ (h >> 16);
        h = h * MIX_MULT;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic logic [63:0] pick_key();
        logic [63:0] k;
        logic [63:0] p10;
        case ($urandom_range(0, 5))
            0: k = 64'($urandom_range(0, 1000));
            1: begin
                // Values around a power of ten, where the digit count changes.
                p10 = 64'd1;
                repeat ($urandom_range(0, 18)) p10 = p10 * 64'd10;
                k = p10 + 64'($urandom_range(0, 2)) - 64'd1;
            end
            2: k = {$urandom, $urandom} >> $urandom_range(0, 63);
            3: case ($urandom_range(0, 3))
                0: k = 64'h7fff_ffff_ffff_ffff;
                1: k = 64'h8000_0000_0000_0000;
                2: k = 64'h8000_0000_0000_0001;
                default: k = 64'h7fff_ffff_ffff_fffe;
            endcase
            default: k = {$urandom, $urandom};
        endcase
        if ($urandom_range(0, 2) == 0)
            k = -k;
        return k;
    endfunction

    task automatic send_key(input logic [63:0] k);
        s_tdata  <= k;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        keys_sent++;
        if (k[KEY_BITS-1])
            neg_sent++;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (hash_q.size() != 0) @(negedge aclk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Scoreboard and watchdog, sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (s_tvalid && s_tready)
                hash_q.push_back(decimal_text_hash(s_tdata));
            if (m_tvalid && m_tready) begin
                if (hash_q.size() == 0) begin
                    $error("hash: result transfer with nothing expected, actual %h", m_tdata);
                    err_count++;
                end else begin
                    if (m_tdata !== hash_q[0]) begin
                        $error("hash: expected %h, actual %h", hash_q[0], m_tdata);
                        err_count++;
                    end
                    void'(hash_q.pop_front());
                    hashes_checked++;
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: no transfer for %0d cycles", STALL_LIMIT);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_keys[i])
            send_key(directed_keys[i]);
        wait_drained();

        for (int i = 0; i < RANDOM_KEYS; i++) begin
            // Idling stops for a middle stretch and for the last part of the run.
            idle_on = !(i >= 400 && i < 500) && i < 850;
            if (i == 200)
                hold_req = 1'b1;
            if (i == 300 || i == 600)
                wait_drained();
            send_key(pick_key());
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("tb: %0d keys hashed (%0d negative, directed extremes included), %0d hashes checked",
                 keys_sent, neg_sent, hashes_checked);
        $display("tb: included a long result stall and drained pauses on the input side");
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
